// ----- rtl/core/sorted_linked_list_pool_manager_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sorted linked list pool manager
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_LINKED_LIST_POOL_MANAGER_MACROS_SVH
`define SORTED_LINKED_LIST_POOL_MANAGER_MACROS_SVH

// Same-cycle implication.
`define SLPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SLPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/slpm_pkg.sv -----
// ---------------------------------------------------------------------------
// slpm_pkg
// Sizes, codes and types shared by the pool manager and its node memory.
// ---------------------------------------------------------------------------
`default_nettype none

package slpm_pkg;

    localparam int NODES  = 16;
    localparam int LISTS  = 8;
    localparam int IDX_W  = $clog2(NODES);
    localparam int LINK_W = $clog2(NODES + 1);
    localparam int LEN_W  = $clog2(NODES + 1);
    localparam int LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int KEY_W  = 32;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NODES);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_COUNT  = 2'd2;
    // no meaning: answered with all-zero fields, nothing changes
    localparam logic [1:0] REQ_NOP    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_NOT_FND  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [LINK_W-1:0]       next;
        logic [LINK_W-1:0]       prev;
    } t_node;

    // Write port of the node memory, one enable per field.
    typedef struct packed {
        logic              we_key;
        logic              we_next;
        logic              we_prev;
        logic [IDX_W-1:0]  addr;
        t_node             data;
    } t_node_wr;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_START, S_TAKE, S_WREQ, S_WCHK,
        S_W0, S_W1, S_W2, S_W3, S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/slpm_node_ram.sv -----
// ---------------------------------------------------------------------------
// slpm_node_ram
// Node store: key, next and prev per node, field write enables, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module slpm_node_ram (
    input  wire logic                      i_clk,
    input  wire slpm_pkg::t_node_wr        i_wr,
    input  wire logic [slpm_pkg::IDX_W-1:0] i_rd_addr,
    output slpm_pkg::t_node                o_rd_data
);

    slpm_pkg::t_node r_mem [slpm_pkg::NODES];
    slpm_pkg::t_node r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_key) begin
            r_mem[i_wr.addr].key <= i_wr.data.key;
        end
        if (i_wr.we_next) begin
            r_mem[i_wr.addr].next <= i_wr.data.next;
        end
        if (i_wr.we_prev) begin
            r_mem[i_wr.addr].prev <= i_wr.data.prev;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_linked_list_pool_manager.sv -----
// Results: a request that needs no walk goes straight to its result; a walk over L nodes
//   comes before the result of a count, a miss, a delete hit or an insert.
// Flow: one word at a time; the next word is taken the cycle after the result is
//   registered, and the result waits in S_OUT while the output register is stalled.
// Reset: synchronous, active low; a pass then rebuilds the free chain in the
//   node memory, during which no input word is accepted.
// ---------------------------------------------------------------------------
// sorted_linked_list_pool_manager
// Pool of nodes holding several ascending doubly linked lists plus a free list.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_linked_list_pool_manager_macros.svh"

module sorted_linked_list_pool_manager (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [2:0]  i_list_number,
    input  wire logic signed [31:0] i_key,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [3:0]       o_node_index,
    output logic [4:0]       o_list_length
);

    localparam int IW = slpm_pkg::IDX_W;
    localparam int LW = slpm_pkg::LINK_W;
    localparam int NW = slpm_pkg::LEN_W;

    slpm_pkg::t_state r_state, n_state;

    // latched request word
    logic [1:0]        r_op, n_op;
    logic [2:0]        r_ln, n_ln;
    logic signed [31:0] r_key, n_key;

    // free list head and list heads (heads reset to null)
    logic [LW-1:0] r_free, n_free;
    logic [LW-1:0] r_head [slpm_pkg::LISTS];
    logic          head_we;
    logic [LW-1:0] head_wd;

    // walk state
    logic [LW-1:0] r_cur, n_cur;     // current node on the walk
    logic [LW-1:0] r_prev, n_prev;   // node before the insert point / victim's prev
    logic [LW-1:0] r_nx, n_nx;       // victim's next on delete
    logic [LW-1:0] r_nfree, n_nfree; // new free head after taking a node
    logic [NW-1:0] r_cnt, n_cnt;     // steps taken / list length
    logic [IW-1:0] r_node, n_node;   // node allocated or freed
    logic [IW-1:0] r_init, n_init;   // free-chain rebuild pointer

    // pending result
    logic [1:0]    r_st, n_st;
    logic [NW-1:0] r_len, n_len;

    // output register
    logic          r_ov, n_ov;
    logic [1:0]    r_ost;
    logic [IW-1:0] r_onode;
    logic [NW-1:0] r_olen;

    slpm_pkg::t_node_wr wr;
    logic [IW-1:0]      rd_addr;
    slpm_pkg::t_node    rd;

    logic          in_acc;
    logic          out_free;
    logic [LW-1:0] head_cur;
    logic          cur_null;

    slpm_node_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ov || !i_out_stall;
    assign head_cur = r_head[r_ln[slpm_pkg::LIST_W-1:0]];
    assign cur_null = (r_cur == slpm_pkg::LINK_NULL) || (r_cnt == NW'(slpm_pkg::NODES));

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            slpm_pkg::S_INIT: begin
                if (r_init == IW'(slpm_pkg::NODES - 1)) begin
                    n_state = slpm_pkg::S_IDLE;
                end
            end
            slpm_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = slpm_pkg::S_START;
                end
            end
            slpm_pkg::S_START: begin
                if (r_op == slpm_pkg::REQ_NOP || 32'(r_ln) >= slpm_pkg::LISTS) begin
                    n_state = slpm_pkg::S_OUT;
                end else if (r_op == slpm_pkg::REQ_INSERT) begin
                    n_state = (r_free == slpm_pkg::LINK_NULL) ? slpm_pkg::S_OUT
                                                              : slpm_pkg::S_TAKE;
                end else begin
                    n_state = (head_cur == slpm_pkg::LINK_NULL) ? slpm_pkg::S_OUT
                                                                : slpm_pkg::S_WREQ;
                end
            end
            slpm_pkg::S_TAKE: n_state = slpm_pkg::S_WREQ;
            slpm_pkg::S_WREQ: begin
                if (!cur_null) begin
                    n_state = slpm_pkg::S_WCHK;
                end else if (r_op == slpm_pkg::REQ_INSERT) begin
                    n_state = slpm_pkg::S_W0;
                end else begin
                    n_state = slpm_pkg::S_OUT;
                end
            end
            slpm_pkg::S_WCHK: begin
                case (r_op)
                    slpm_pkg::REQ_INSERT:
                        n_state = (rd.key < r_key) ? slpm_pkg::S_WREQ : slpm_pkg::S_W0;
                    slpm_pkg::REQ_DELETE:
                        n_state = (rd.key == r_key) ? slpm_pkg::S_W0 : slpm_pkg::S_WREQ;
                    default: n_state = slpm_pkg::S_WREQ;
                endcase
            end
            slpm_pkg::S_W0: n_state = slpm_pkg::S_W1;
            slpm_pkg::S_W1: n_state = slpm_pkg::S_W2;
            slpm_pkg::S_W2: n_state = slpm_pkg::S_W3;
            slpm_pkg::S_W3: n_state = slpm_pkg::S_OUT;
            slpm_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = slpm_pkg::S_IDLE;
                end
            end
            default: n_state = slpm_pkg::S_IDLE;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb begin
        n_op = r_op; n_ln = r_ln; n_key = r_key;
        n_free = r_free; n_cur = r_cur; n_prev = r_prev; n_nx = r_nx;
        n_nfree = r_nfree; n_cnt = r_cnt; n_node = r_node; n_init = r_init;
        n_st = r_st; n_len = r_len;
        n_ov = r_ov && i_out_stall;
        head_we = 1'b0;
        head_wd = slpm_pkg::LINK_NULL;
        wr = '0;
        rd_addr = r_cur[IW-1:0];
        o_in_stall = (r_state != slpm_pkg::S_IDLE);

        case (r_state)
            slpm_pkg::S_INIT: begin
                // rebuild free chain: next = i+1, prev = i-1 (first prev null)
                wr.we_next   = 1'b1;
                wr.we_prev   = 1'b1;
                wr.addr      = r_init;
                wr.data.next = LW'(r_init) + LW'(1);
                wr.data.prev = (r_init == '0) ? slpm_pkg::LINK_NULL
                                              : LW'(r_init) - LW'(1);
                n_init       = r_init + IW'(1);
            end
            slpm_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op = i_req_type; n_ln = i_list_number; n_key = i_key;
                    n_st = slpm_pkg::ST_OK; n_len = '0; n_node = '0;
                end
            end
            slpm_pkg::S_START: begin
                n_cur  = head_cur;
                n_prev = slpm_pkg::LINK_NULL;
                n_cnt  = '0;
                rd_addr = r_free[IW-1:0];
                if (r_op == slpm_pkg::REQ_NOP) begin
                    n_st = slpm_pkg::ST_OK;
                end else if (32'(r_ln) >= slpm_pkg::LISTS) begin
                    n_st = slpm_pkg::ST_EMPTY;
                end else if (r_op == slpm_pkg::REQ_INSERT) begin
                    if (r_free == slpm_pkg::LINK_NULL) begin
                        n_st = slpm_pkg::ST_NO_FREE;
                    end else begin
                        n_node = r_free[IW-1:0];
                    end
                end else if (head_cur == slpm_pkg::LINK_NULL) begin
                    n_st = slpm_pkg::ST_EMPTY;
                end
            end
            slpm_pkg::S_TAKE: begin
                n_nfree = rd.next;
            end
            slpm_pkg::S_WREQ: begin
                if (cur_null) begin
                    if (r_op == slpm_pkg::REQ_DELETE) begin
                        n_st = slpm_pkg::ST_NOT_FND;
                    end else if (r_op == slpm_pkg::REQ_COUNT) begin
                        n_len = r_cnt;
                    end
                end
            end
            slpm_pkg::S_WCHK: begin
                if (r_op == slpm_pkg::REQ_DELETE && rd.key == r_key) begin
                    n_prev = rd.prev;
                    n_nx   = rd.next;
                    n_node = r_cur[IW-1:0];
                end else if (r_op != slpm_pkg::REQ_INSERT || rd.key < r_key) begin
                    n_prev = r_cur;
                    n_cur  = rd.next;
                    n_cnt  = r_cnt + NW'(1);
                end
            end
            slpm_pkg::S_W0: begin
                if (r_op == slpm_pkg::REQ_INSERT) begin
                    wr.we_key = 1'b1; wr.we_next = 1'b1; wr.we_prev = 1'b1;
                    wr.addr = r_node;
                    wr.data.key = r_key; wr.data.next = r_cur; wr.data.prev = r_prev;
                    n_free = r_nfree;
                end else if (r_prev != slpm_pkg::LINK_NULL) begin
                    wr.we_next = 1'b1; wr.addr = r_prev[IW-1:0]; wr.data.next = r_nx;
                end else begin
                    head_we = 1'b1; head_wd = r_nx;
                end
            end
            slpm_pkg::S_W1: begin
                if (r_op == slpm_pkg::REQ_INSERT) begin
                    if (r_prev != slpm_pkg::LINK_NULL) begin
                        wr.we_next = 1'b1; wr.addr = r_prev[IW-1:0];
                        wr.data.next = LW'(r_node);
                    end else begin
                        head_we = 1'b1; head_wd = LW'(r_node);
                    end
                end else if (r_nx != slpm_pkg::LINK_NULL) begin
                    wr.we_prev = 1'b1; wr.addr = r_nx[IW-1:0]; wr.data.prev = r_prev;
                end
            end
            slpm_pkg::S_W2: begin
                if (r_op == slpm_pkg::REQ_INSERT) begin
                    wr.we_prev   = (r_cur != slpm_pkg::LINK_NULL);
                    wr.addr      = r_cur[IW-1:0];
                    wr.data.prev = LW'(r_node);
                end else begin
                    // victim goes to the free list head
                    wr.we_next = 1'b1; wr.we_prev = 1'b1; wr.addr = r_node;
                    wr.data.next = r_free; wr.data.prev = slpm_pkg::LINK_NULL;
                end
            end
            slpm_pkg::S_W3: begin
                if (r_op == slpm_pkg::REQ_INSERT) begin
                    wr.we_prev   = (r_nfree != slpm_pkg::LINK_NULL);
                    wr.addr      = r_nfree[IW-1:0];
                    wr.data.prev = slpm_pkg::LINK_NULL;
                end else begin
                    wr.we_prev   = (r_free != slpm_pkg::LINK_NULL);
                    wr.addr      = r_free[IW-1:0];
                    wr.data.prev = LW'(r_node);
                    n_free       = LW'(r_node);
                end
            end
            slpm_pkg::S_OUT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slpm_pkg::S_INIT;
            r_init  <= '0;
            r_free  <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < slpm_pkg::LISTS; i++) begin
                r_head[i] <= slpm_pkg::LINK_NULL;
            end
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_free  <= n_free;
            r_ov    <= n_ov;
            if (head_we) begin
                r_head[r_ln[slpm_pkg::LIST_W-1:0]] <= head_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_ln <= n_ln; r_key <= n_key;
        r_cur <= n_cur; r_prev <= n_prev; r_nx <= n_nx; r_nfree <= n_nfree;
        r_cnt <= n_cnt; r_node <= n_node; r_st <= n_st; r_len <= n_len;
        if (r_state == slpm_pkg::S_OUT && out_free) begin
            r_ost   <= r_st;
            r_onode <= (r_st == slpm_pkg::ST_OK) ? r_node : '0;
            r_olen  <= r_len;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_ost;
    assign o_node_index  = r_onode;
    assign o_list_length = r_olen;

    // ---------------- assertions ----------------
    `SLPM_ASSERT_IMP(a_node_zero_on_err, o_out_valid && o_status != slpm_pkg::ST_OK,
        o_node_index == '0, "node index set on failed request")
    `SLPM_ASSERT_IMP(a_len_only_ok, o_out_valid && o_list_length != '0,
        o_status == slpm_pkg::ST_OK, "length reported with error status")
    `SLPM_ASSERT_NXT(a_busy_after_acc, i_in_valid && !o_in_stall,
        o_in_stall, "second word accepted while busy")

endmodule

`default_nettype wire

// ----- tb/sorted_linked_list_pool_manager_tb.sv -----
// ---------------------------------------------------------------------------
// sorted_linked_list_pool_manager_tb
// Drives insert, delete, count and no-op words into the pool manager and checks
// each result against a behavioral copy of the node pool kept in the bench.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_linked_list_pool_manager_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = slpm_pkg::NODES;
    localparam int LISTS = slpm_pkg::LISTS;

    typedef struct {
        logic [1:0]         req;
        logic [2:0]         lst;
        logic signed [31:0] key;
    } t_req_word;

    typedef struct {
        logic [1:0] status;
        logic [3:0] node;
        logic [4:0] len;
    } t_res_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_req_type = '0;
    logic [2:0]         i_list_number = '0;
    logic signed [31:0] i_key = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic [3:0]         o_node_index;
    logic [4:0]         o_list_length;

    sorted_linked_list_pool_manager dut (.*);

    always #4 i_clk = ~i_clk;

    // Bench copy of the pool. Links use NODES as the null value.
    logic signed [31:0] pool_key [NODES];
    int                 pool_next [NODES];
    int                 pool_prev [NODES];
    int                 head_of [LISTS];
    int                 free_top;

    t_req_word pending_words[$];
    t_res_word expected_results[$];

    int  errors = 0;
    int  words_sent = 0;
    int  results_seen = 0;
    int  stat_hits [4];
    bit  calm = 1'b0;          // no idling near the end
    bit  hold_input = 1'b0;    // sender pause request
    bit  long_hold = 1'b0;     // receiver long stall, timed by its own process
    int  in_gap = 0;
    int  out_gap = 0;

    task automatic pool_reset();
        for (int i = 0; i < NODES; i++) begin
            pool_key[i]  = '0;
            pool_next[i] = i + 1;
            pool_prev[i] = (i == 0) ? NODES : i - 1;
        end
        foreach (head_of[i]) head_of[i] = NODES;
        free_top = 0;
    endtask

    // Applies one request to the bench pool and returns what the block must answer.
    function automatic t_res_word pool_apply(t_req_word w);
        t_res_word r;
        int c, p, n, nx, steps;
        r = '{slpm_pkg::ST_OK, 4'd0, 5'd0};
        if (w.req == slpm_pkg::REQ_NOP) begin
            // ignored request: all zero
        end else if (w.lst >= LISTS) begin
            r.status = slpm_pkg::ST_EMPTY;
        end else if (w.req == slpm_pkg::REQ_INSERT) begin
            n = free_top;
            if (n >= NODES) begin
                r.status = slpm_pkg::ST_NO_FREE;
            end else begin
                free_top = pool_next[n];
                if (free_top < NODES) pool_prev[free_top] = NODES;
                pool_key[n] = w.key;
                p = NODES;
                c = head_of[w.lst];
                steps = 0;
                // new key goes ahead of the first node with key >= it
                while (c < NODES && pool_key[c] < w.key && steps < NODES) begin
                    p = c;
                    c = pool_next[c];
                    steps++;
                end
                if (c >= NODES) c = NODES;
                pool_prev[n] = p;
                pool_next[n] = c;
                if (p < NODES) pool_next[p] = n;
                else head_of[w.lst] = n;
                if (c < NODES) pool_prev[c] = n;
                r.node = n[3:0];
            end
        end else if (w.req == slpm_pkg::REQ_DELETE) begin
            c = head_of[w.lst];
            if (c >= NODES) begin
                r.status = slpm_pkg::ST_EMPTY;
            end else begin
                steps = 0;
                while (c < NODES && pool_key[c] != w.key && steps < NODES) begin
                    c = pool_next[c];
                    steps++;
                end
                if (c >= NODES || pool_key[c] != w.key) begin
                    r.status = slpm_pkg::ST_NOT_FND;
                end else begin
                    p  = pool_prev[c];
                    nx = pool_next[c];
                    if (p < NODES) pool_next[p] = nx;
                    else head_of[w.lst] = nx;
                    if (nx < NODES) pool_prev[nx] = p;
                    // freed node goes on top of the free list
                    pool_next[c] = free_top;
                    pool_prev[c] = NODES;
                    if (free_top < NODES) pool_prev[free_top] = c;
                    free_top = c;
                    r.node = c[3:0];
                end
            end
        end else begin
            c = head_of[w.lst];
            if (c >= NODES) begin
                r.status = slpm_pkg::ST_EMPTY;
            end else begin
                steps = 0;
                while (c < NODES && steps < NODES) begin
                    steps++;
                    c = pool_next[c];
                end
                r.len = steps[4:0];
            end
        end
        return r;
    endfunction

    // Driver: keeps a word on the port until accepted; random idle bursts.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(pool_apply('{i_req_type, i_list_number, i_key}));
                words_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0 && !hold_input) begin
                    t_req_word w;
                    w = pending_words.pop_front();
                    i_in_valid    <= 1'b1;
                    i_req_type    <= w.req;
                    i_list_number <= w.lst;
                    i_key         <= w.key;
                    if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 3);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                t_res_word e;
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    stat_hits[e.status]++;
                    if (o_status !== e.status) begin
                        $error("status expected %0d got %0d", e.status, o_status);
                        errors++;
                    end
                    if (o_node_index !== e.node) begin
                        $error("node_index expected %0d got %0d", e.node, o_node_index);
                        errors++;
                    end
                    if (o_list_length !== e.len) begin
                        $error("list_length expected %0d got %0d", e.len, o_list_length);
                        errors++;
                    end
                end
            end
            if (long_hold) begin
                i_out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 3);
            end
        end
    end

    function automatic t_req_word rand_word();
        t_req_word w;
        int pick;
        pick = $urandom_range(0, 99);
        w.req = (pick < 45) ? slpm_pkg::REQ_INSERT :
                (pick < 80) ? slpm_pkg::REQ_DELETE :
                (pick < 97) ? slpm_pkg::REQ_COUNT : slpm_pkg::REQ_NOP;
        w.lst = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
        // small key set so deletes hit and duplicates occur; sometimes full range
        w.key = ($urandom_range(0, 4) == 0) ? $signed($urandom) :
                $signed(32'($urandom_range(0, 12)) - 32'sd6);
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        pool_reset();
        foreach (stat_hits[i]) stat_hits[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list cases, extremes, equal keys, head ties, pool full.
        pending_words.push_back('{slpm_pkg::REQ_COUNT,  3'd0, 32'sd0});
        pending_words.push_back('{slpm_pkg::REQ_DELETE, 3'd7, 32'sd5});
        pending_words.push_back('{slpm_pkg::REQ_NOP,    3'd7, 32'hFFFF_FFFF});
        pending_words.push_back('{slpm_pkg::REQ_INSERT, 3'd7, 32'sh7FFF_FFFF});
        pending_words.push_back('{slpm_pkg::REQ_INSERT, 3'd7, 32'sh8000_0000});
        pending_words.push_back('{slpm_pkg::REQ_INSERT, 3'd7, 32'sh8000_0000});
        pending_words.push_back('{slpm_pkg::REQ_INSERT, 3'd7, 32'sd0});
        pending_words.push_back('{slpm_pkg::REQ_DELETE, 3'd7, 32'sd1});
        pending_words.push_back('{slpm_pkg::REQ_COUNT,  3'd7, 32'sd0});
        pending_words.push_back('{slpm_pkg::REQ_DELETE, 3'd7, 32'sh8000_0000});
        pending_words.push_back('{slpm_pkg::REQ_DELETE, 3'd7, 32'sh7FFF_FFFF});
        for (int i = 0; i < 14; i++)
            pending_words.push_back('{slpm_pkg::REQ_INSERT, 3'(i % 2), 32'(5 - i)});
        wait_drained();
        // pool is now full: no free node
        pending_words.push_back('{slpm_pkg::REQ_INSERT, 3'd3, 32'sd1});
        pending_words.push_back('{slpm_pkg::REQ_COUNT,  3'd1, 32'sd0});
        wait_drained();

        // Receiver holds off while the sender keeps offering words.
        fork
            begin
                long_hold = 1'b1;
                repeat (200) @(posedge i_clk);
                long_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 30; i++) pending_words.push_back(rand_word());
        wait_drained();

        for (int i = 0; i < 1200; i++) begin
            if (i == 500) begin
                // sender pauses until everything has come back
                while (pending_words.size() > 0 || i_in_valid) @(posedge i_clk);
                hold_input = 1'b1;
                wait_drained();
                hold_input = 1'b0;
            end
            if (i == 1050) calm = 1'b1;
            pending_words.push_back(rand_word());
            while (pending_words.size() > 4) @(posedge i_clk);
        end
        wait_drained();

        $display("covered %0d words: ok %0d, no free %0d, not found %0d, empty %0d",
                 words_sent, stat_hits[slpm_pkg::ST_OK], stat_hits[slpm_pkg::ST_NO_FREE],
                 stat_hits[slpm_pkg::ST_NOT_FND], stat_hits[slpm_pkg::ST_EMPTY]);
        if (errors == 0 && expected_results.size() == 0)
            $display("sorted_linked_list_pool_manager_tb passed");
        else
            $display("sorted_linked_list_pool_manager_tb failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("sorted_linked_list_pool_manager_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/slpm_pkg.sv
rtl/core/slpm_node_ram.sv
rtl/core/sorted_linked_list_pool_manager.sv
tb/sorted_linked_list_pool_manager_tb.sv
